FILE: rtl/dtip_pkg.sv
// dtip_pkg: shared types and constants for the decimal text integer parser.
// Used by dtip_front, dtip_queue, dtip_back and the top level.
// No dependencies.
`timescale 1ns / 1ps

package dtip_pkg;

  // Accumulator width; the narrow mode always wraps at NARROW_W bits.
  localparam int ACC_WIDTH = 64;
  localparam int NARROW_W  = 32;

  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // Queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST   = 2'd2;

  // Characters of interest.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_DIGITS = 2'd2;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_MINUS = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_TERM  = 2'd3
  } kind_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    kind_t              kind;
    logic [DIGIT_W-1:0] digit;
    logic               wide;   // width selected when the character arrived
    logic               comma;  // terminator was a comma
  } op_t;

  typedef struct packed {
    logic signed_mode;
    logic wide_mode;
    logic list_mode;
  } cfg_t;

endpackage

FILE: rtl/dtip_front.sv
// dtip_front: configuration registers and character classifier.
// Depends on dtip_pkg.
`timescale 1ns / 1ps

module dtip_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dtip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtip_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          char_valid,
  output logic                          char_stall,
  input  logic [dtip_pkg::CHAR_W-1:0]   character,
  input  logic                          queue_full,
  output logic                          push,
  output dtip_pkg::op_t                 push_op
);

  dtip_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signed_mode <= 1'b1;
      cfg.wide_mode   <= 1'b1;
      cfg.list_mode   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        dtip_pkg::CFG_SIGNED: cfg.signed_mode <= cfg_data[0];
        dtip_pkg::CFG_WIDE:   cfg.wide_mode   <= cfg_data[0];
        dtip_pkg::CFG_LIST:   cfg.list_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    push_op.digit = character[dtip_pkg::DIGIT_W-1:0];  // '0' is 0x30
    push_op.wide  = cfg.wide_mode;
    push_op.comma = (character == dtip_pkg::CHAR_COMMA);
    if (character == dtip_pkg::CHAR_NUL ||
        (character == dtip_pkg::CHAR_COMMA && cfg.list_mode)) begin
      push_op.kind = dtip_pkg::KIND_TERM;
    end else if (character inside {[dtip_pkg::CHAR_ZERO:dtip_pkg::CHAR_NINE]}) begin
      push_op.kind = dtip_pkg::KIND_DIGIT;
    end else if (character == dtip_pkg::CHAR_MINUS && cfg.signed_mode) begin
      push_op.kind = dtip_pkg::KIND_MINUS;
    end else begin
      push_op.kind = dtip_pkg::KIND_BAD;
    end
  end

  assign char_stall = queue_full;
  assign push       = char_valid && !queue_full;

endmodule

FILE: rtl/dtip_queue.sv
// dtip_queue: short FIFO of classified characters between front and back.
// Depends on dtip_pkg.
`timescale 1ns / 1ps

module dtip_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtip_pkg::op_t push_op,
  input  logic          pop,
  output logic          head_valid,
  output dtip_pkg::op_t head_op,
  output logic          full
);

  dtip_pkg::op_t entries [dtip_pkg::QUEUE_DEPTH];

  logic [dtip_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [dtip_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [dtip_pkg::Q_CNT_W-1:0] count;

  localparam logic [dtip_pkg::Q_PTR_W-1:0] LAST_PTR =
    dtip_pkg::Q_PTR_W'(dtip_pkg::QUEUE_DEPTH - 1);
  localparam logic [dtip_pkg::Q_CNT_W-1:0] FULL_CNT =
    dtip_pkg::Q_CNT_W'(dtip_pkg::QUEUE_DEPTH);
  localparam logic [dtip_pkg::Q_CNT_W-1:0] CNT_ONE =
    dtip_pkg::Q_CNT_W'(1);

  assign head_valid = (count != '0);
  assign full       = (count == FULL_CNT);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + CNT_ONE;
      end else if (pop && !push) begin
        count <= count - CNT_ONE;
      end
    end
  end

endmodule

FILE: rtl/dtip_back.sv
// dtip_back: parse state, multiply-by-ten accumulator and result register.
// Depends on dtip_pkg.
`timescale 1ns / 1ps

module dtip_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           head_valid,
  input  dtip_pkg::op_t                  head_op,
  output logic                           pop,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [dtip_pkg::VALUE_W-1:0]   value,
  output logic [dtip_pkg::STATUS_W-1:0]  status,
  output logic                           ended_by_comma
);

  localparam logic [dtip_pkg::ACC_WIDTH-1:0] NARROW_MASK =
    dtip_pkg::ACC_WIDTH'({dtip_pkg::NARROW_W{1'b1}});

  logic [dtip_pkg::ACC_WIDTH-1:0] accumulator;
  logic                           saw_digit;
  logic                           is_negative;
  logic                           at_start;
  logic                           bad_char_seen;

  logic [dtip_pkg::ACC_WIDTH-1:0] mask;
  logic [dtip_pkg::ACC_WIDTH-1:0] accumulator_next;
  logic [dtip_pkg::ACC_WIDTH-1:0] final_value;
  logic                           term_pop;

  // A terminator needs a free result register; everything else retires at once.
  assign pop = head_valid &&
               (head_op.kind != dtip_pkg::KIND_TERM || !result_valid || !result_stall);
  assign term_pop = pop && (head_op.kind == dtip_pkg::KIND_TERM);

  always_comb begin
    mask = head_op.wide ? '1 : NARROW_MASK;
    accumulator_next = ((accumulator << 3) + (accumulator << 1) +
                        dtip_pkg::ACC_WIDTH'(head_op.digit)) & mask;
    final_value = (is_negative ? ('0 - accumulator) : accumulator) & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      saw_digit     <= 1'b0;
      is_negative   <= 1'b0;
      at_start      <= 1'b1;
      bad_char_seen <= 1'b0;
    end else if (pop) begin
      case (head_op.kind)
        dtip_pkg::KIND_TERM: begin
          accumulator   <= '0;
          saw_digit     <= 1'b0;
          is_negative   <= 1'b0;
          at_start      <= 1'b1;
          bad_char_seen <= 1'b0;
        end
        dtip_pkg::KIND_DIGIT: begin
          accumulator <= accumulator_next;
          saw_digit   <= 1'b1;
          at_start    <= 1'b0;
        end
        dtip_pkg::KIND_MINUS: begin
          // a minus is only legal as the first character
          if (at_start) begin
            is_negative <= 1'b1;
          end else begin
            bad_char_seen <= 1'b1;
          end
          at_start <= 1'b0;
        end
        default: begin
          bad_char_seen <= 1'b1;
          at_start      <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (term_pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_pop) begin
      ended_by_comma <= head_op.comma;
      if (bad_char_seen) begin
        status <= dtip_pkg::STATUS_BAD_CHAR;
        value  <= '0;
      end else if (!saw_digit) begin
        status <= dtip_pkg::STATUS_NO_DIGITS;
        value  <= '0;
      end else begin
        status <= dtip_pkg::STATUS_OK;
        value  <= dtip_pkg::VALUE_W'(final_value);
      end
    end
  end

endmodule

FILE: rtl/decimal_text_integer_parser_core.sv
// decimal_text_integer_parser_core: top level of the ASCII decimal parser.
// Depends on dtip_pkg, dtip_front, dtip_queue and dtip_back.
`timescale 1ns / 1ps

// Streaming ASCII decimal-to-integer parser. One character is taken per
// transfer on the char channel, and one character can be taken every clock
// cycle while char_stall is low: the accumulator update (acc*10 + digit as two
// shifts and an add) is the loop that sets this rate. A NUL, or a comma when
// list_mode is set, ends the number and produces one result transfer with the
// value, a status (0 ok, 1 invalid character, 2 no digits) and whether a comma
// ended it; other characters produce no result. A result is presented after
// its terminator has passed through the queue entry and the result register,
// and a stalled earlier result holds the terminator in the queue. Invalid
// characters are remembered until the terminator, which then reports them with
// value 0 and clears the parse state. Values wrap at 32 bits (wide_mode 0) or
// 64 bits (wide_mode 1); bits above the selected width read as zero. A two-
// entry queue sits between the classifier and the accumulator, and the result
// sits in its own register, so a stalled result does not stop input characters
// until the queue fills. Configuration registers (index 0 signed_mode, 1
// wide_mode, 2 list_mode, all reset to 1) are written through cfg_write, and
// should only change while no number is in progress; the width in force when
// each character is taken is the one applied to it.

module decimal_text_integer_parser_core (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_write,
  input  logic [dtip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtip_pkg::CFG_DATA_W-1:0]  cfg_data,
  // character input channel
  input  logic                             char_valid,
  output logic                             char_stall,
  input  logic [dtip_pkg::CHAR_W-1:0]      character,
  // result output channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [dtip_pkg::VALUE_W-1:0]     value,
  output logic [dtip_pkg::STATUS_W-1:0]    status,
  output logic                             ended_by_comma
);

  logic          push;
  dtip_pkg::op_t push_op;
  logic          queue_full;
  logic          head_valid;
  dtip_pkg::op_t head_op;
  logic          pop;

  // Front end: config registers and per-character classification.
  dtip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  // Decoupling queue: lets the front keep taking characters while the back
  // waits for a stalled result to drain.
  dtip_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .full       (queue_full)
  );

  // Back end: accumulator, sign and error tracking, result register.
  dtip_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_op        (head_op),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .value          (value),
    .status         (status),
    .ended_by_comma (ended_by_comma)
  );

endmodule
